// ===== design/deque_pkg.sv =====
// package: shared types, codes and defaults for the double-ended queue
`default_nettype none
package deque_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // command codes carried in the request
  typedef enum logic [1:0] {
    CMD_PUSH_RIGHT = 2'd0,
    CMD_POP_LEFT   = 2'd1,
    CMD_POP_RIGHT  = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    CS_IDLE,
    CS_FILL
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] item_value;
  } deque_req_t;

  typedef struct packed {
    logic [31:0] popped_value;
    status_e     status;
    logic [4:0]  element_count;
    logic        is_empty;
    logic [31:0] left_value;
    logic [31:0] right_value;
  } deque_rsp_t;

endpackage
`default_nettype wire

// ===== design/deque_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module deque_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/deque_ctrl.sv =====
// controller: ring pointers, cached end values and ram sequencing
`default_nettype none
module deque_ctrl #(
  parameter int unsigned DEPTH      = deque_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deque_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire deque_pkg::deque_req_t in_req_i,
  input  wire logic                  out_free_i,
  output logic                       res_valid_o,
  output deque_pkg::deque_rsp_t      res_o
);
  import deque_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ctrl_state_e         state_q, state_d;
  logic [PW-1:0]       lp_q, lp_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] lval_q, lval_d, rval_q, rval_d, popped_q, popped_d;
  logic                refresh_left_q, refresh_left_d;

  logic                  wr_en, rd_en;
  logic [PW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  logic                  accept;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] b, logic [PW-1:0] o);
    logic [PW:0] s;
    s = {1'b0, b} + {1'b0, o};
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  function automatic deque_rsp_t make_rsp(logic [DATA_WIDTH-1:0] popped, status_e st,
                                          logic [CW-1:0] cnt, logic [DATA_WIDTH-1:0] lv,
                                          logic [DATA_WIDTH-1:0] rv);
    deque_rsp_t r;
    r.popped_value  = 32'(popped);
    r.status        = st;
    r.element_count = 5'(cnt);
    r.is_empty      = (cnt == '0);
    r.left_value    = (cnt == '0) ? '0 : 32'(lv);
    r.right_value   = (cnt == '0) ? '0 : 32'(rv);
    return r;
  endfunction

  deque_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign in_ready_o = (state_q == CS_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    lp_d           = lp_q;
    cnt_d          = cnt_q;
    lval_d         = lval_q;
    rval_d         = rval_q;
    popped_d       = popped_q;
    refresh_left_d = refresh_left_q;
    wr_en          = 1'b0;
    wr_addr        = wrap_add(lp_q, PW'(cnt_q));
    wr_data        = DATA_WIDTH'(in_req_i.item_value);
    rd_en          = 1'b0;
    rd_addr        = wrap_add(lp_q, PW'(1));
    res_valid_o    = 1'b0;
    res_o          = make_rsp('0, ST_OK, cnt_q, lval_q, rval_q);

    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          case (cmd_e'(in_req_i.command))
            CMD_PUSH_RIGHT: begin
              res_valid_o = 1'b1;
              if (cnt_q == CW'(DEPTH)) begin
                res_o = make_rsp('0, ST_OVERFLOW, cnt_q, lval_q, rval_q);
              end else begin
                wr_en  = 1'b1;
                cnt_d  = cnt_q + CW'(1);
                rval_d = wr_data;
                if (cnt_q == '0) begin
                  lval_d = wr_data;
                end
                res_o = make_rsp('0, ST_OK, cnt_d, lval_d, rval_d);
              end
            end
            CMD_POP_LEFT, CMD_POP_RIGHT: begin
              if (cnt_q == '0) begin
                res_valid_o = 1'b1;
                res_o = make_rsp('0, ST_UNDERFLOW, cnt_q, lval_q, rval_q);
              end else begin
                // refresh the vacated end from the ram next cycle
                cnt_d   = cnt_q - CW'(1);
                state_d = CS_FILL;
                rd_en   = (cnt_d != '0);
                if (cmd_e'(in_req_i.command) == CMD_POP_LEFT) begin
                  popped_d       = lval_q;
                  lp_d           = wrap_add(lp_q, PW'(1));
                  rd_addr        = lp_d;
                  refresh_left_d = 1'b1;
                end else begin
                  popped_d       = rval_q;
                  rd_addr        = wrap_add(lp_q, PW'(cnt_q - CW'(2)));
                  refresh_left_d = 1'b0;
                end
              end
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end
      CS_FILL: begin
        if (cnt_q != '0) begin
          if (refresh_left_q) begin
            lval_d = rd_data;
          end else begin
            rval_d = rd_data;
          end
        end
        res_valid_o = 1'b1;
        res_o       = make_rsp(popped_q, ST_OK, cnt_q, lval_d, rval_d);
        state_d     = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= CS_IDLE;
      lp_q           <= '0;
      cnt_q          <= '0;
      refresh_left_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      lp_q           <= lp_d;
      cnt_q          <= cnt_d;
      refresh_left_q <= refresh_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lval_q   <= lval_d;
    rval_q   <= rval_d;
    popped_q <= popped_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_lp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, lp_q} < (PW+1)'(DEPTH))
    else $error("left pointer beyond depth");

  a_fill_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CS_FILL |=> state_q == CS_IDLE)
    else $error("fill state held longer than one cycle");

  a_fill_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CS_FILL |-> res_valid_o && !in_ready_o)
    else $error("pop result not produced in fill cycle");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("ram read and write in the same cycle");

endmodule
`default_nettype wire

// ===== design/double_ended_queue_top.sv =====
// top level: double-ended queue with request and result channels
//
// usage
// - request channel (in_valid_i / in_ready_o / in_req_i) carries a command
//   (push at right end, pop left end, pop right end) and a value for pushes
// - result channel (out_valid_o / out_ready_i / out_rsp_o) returns one result
//   per request: popped value, status, element count, empty flag and peeks
//   of the leftmost and rightmost elements after the request
// - a push, an overflow, an underflow or an unused command code is answered
//   without a fill state; the result sits in the output register after the accepting edge
// - a pop that succeeds passes through the fill state: the ram read that
//   refreshes the vacated end is registered, so the result is registered at
//   the end of the fill state and in_ready_o is low during that state
// - sustained rate is one request per cycle for pushes while the receiver
//   keeps up; a pop holds off new requests until its fill state is done
// - the output register frees the request side: a new request is taken while
//   a result waits, as long as that result is taken in the same cycle
// - when the receiver stalls, the result holds and no request is taken until
//   the receiver takes it
// - reset empties the queue and clears the result valid flag; ram contents
//   are left as they are and are read only after a push wrote them
`default_nettype none
module double_ended_queue_top #(
  parameter int unsigned DEPTH      = deque_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deque_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire deque_pkg::deque_req_t in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output deque_pkg::deque_rsp_t      out_rsp_o
);
  import deque_pkg::*;

  // output register
  logic       out_valid_q, out_valid_d;
  deque_rsp_t out_rsp_q;

  // controller result
  logic       res_valid;
  deque_rsp_t res;
  logic       out_free;

  // the slot is free when empty or when its result leaves this cycle
  assign out_free = !out_valid_q || out_ready_i;

  deque_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // a new result only arrives when the slot is free
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result would overwrite a waiting result");

  a_ready_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> out_free)
    else $error("request taken without a free output slot");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("result lost on its way to the output register");

endmodule
`default_nettype wire
